/* rtl/core/iolt_pkg.sv */
// Shared types and constants for the indexed ordered list table.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package iolt_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WIDTH_DEF = 32;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;
  localparam int FUNC_W    = 3;
  localparam int POS_W     = 5;
  localparam int VAL_W     = 32;
  localparam int CNT_OUT_W = 5;

  localparam logic [FUNC_W-1:0] FN_READ   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_WRITE  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_APPEND = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd5;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PL_NONE,
    PL_READ,
    PL_WRITE,
    PL_APPEND,
    PL_SHIFT_UP,
    PL_SHIFT_DOWN
  } plan_t;

  typedef enum logic [1:0] {
    WA_POS,
    WA_COUNT,
    WA_UP,
    WA_DOWN
  } wa_sel_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_DECODE,
    CS_SH_RD,
    CS_SH_WR,
    CS_PUT,
    CS_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic    take;
    logic    rd_en;
    logic    rd_cursor;
    logic    wr_en;
    wa_sel_t wsel;
    logic    wdata_shift;
    logic    cur_load;
    logic    cur_step;
    logic    finish;
  } dp_cmd_t;

  typedef struct packed {
    plan_t plan;
    logic  at_pos;
    logic  at_top;
    logic  out_free;
  } dp_stat_t;

endpackage

/* rtl/core/iolt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module iolt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/iolt_ctrl.sv */
// Controller for the indexed ordered list table: sequences decode, shift and result.
// Depends on iolt_pkg.
`timescale 1ns / 1ps

module iolt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  iolt_pkg::dp_stat_t stat,
  output iolt_pkg::dp_cmd_t  cmd
);

  iolt_pkg::ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iolt_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      iolt_pkg::CS_IDLE: begin
        if (s_tvalid) state_next = iolt_pkg::CS_DECODE;
      end
      iolt_pkg::CS_DECODE: begin
        unique case (stat.plan)
          iolt_pkg::PL_SHIFT_UP,
          iolt_pkg::PL_SHIFT_DOWN: state_next = iolt_pkg::CS_SH_RD;
          default:                 state_next = iolt_pkg::CS_FINISH;
        endcase
      end
      iolt_pkg::CS_SH_RD: state_next = iolt_pkg::CS_SH_WR;
      iolt_pkg::CS_SH_WR: begin
        if (stat.plan == iolt_pkg::PL_SHIFT_UP) begin
          state_next = stat.at_pos ? iolt_pkg::CS_PUT : iolt_pkg::CS_SH_RD;
        end else begin
          state_next = stat.at_top ? iolt_pkg::CS_FINISH : iolt_pkg::CS_SH_RD;
        end
      end
      iolt_pkg::CS_PUT: state_next = iolt_pkg::CS_FINISH;
      iolt_pkg::CS_FINISH: begin
        if (stat.out_free) state_next = iolt_pkg::CS_IDLE;
      end
      default: state_next = iolt_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    s_tready        = 1'b0;
    cmd             = '0;
    cmd.wsel        = iolt_pkg::WA_POS;
    unique case (state)
      iolt_pkg::CS_IDLE: begin
        s_tready = !rst;
        cmd.take = s_tvalid && !rst;
      end
      iolt_pkg::CS_DECODE: begin
        unique case (stat.plan)
          iolt_pkg::PL_READ: cmd.rd_en = 1'b1;
          iolt_pkg::PL_WRITE: cmd.wr_en = 1'b1;
          iolt_pkg::PL_APPEND: begin
            cmd.wr_en = 1'b1;
            cmd.wsel  = iolt_pkg::WA_COUNT;
          end
          iolt_pkg::PL_SHIFT_UP,
          iolt_pkg::PL_SHIFT_DOWN: cmd.cur_load = 1'b1;
          default: ;
        endcase
      end
      iolt_pkg::CS_SH_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_cursor = 1'b1;
      end
      iolt_pkg::CS_SH_WR: begin
        cmd.wr_en       = 1'b1;
        cmd.wdata_shift = 1'b1;
        if (stat.plan == iolt_pkg::PL_SHIFT_UP) begin
          cmd.wsel     = iolt_pkg::WA_UP;
          cmd.cur_step = !stat.at_pos;
        end else begin
          cmd.wsel     = iolt_pkg::WA_DOWN;
          cmd.cur_step = !stat.at_top;
        end
      end
      iolt_pkg::CS_PUT: cmd.wr_en = 1'b1;
      iolt_pkg::CS_FINISH: cmd.finish = stat.out_free;
      default: ;
    endcase
  end

endmodule

/* rtl/core/iolt_dp.sv */
// Datapath for the indexed ordered list table: item fields, fill count, entry RAM,
// shift cursor and result register. Depends on iolt_pkg and iolt_ram.
`timescale 1ns / 1ps

module iolt_dp #(
  parameter int DEPTH = iolt_pkg::DEPTH_DEF,
  parameter int WIDTH = iolt_pkg::WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  iolt_pkg::dp_cmd_t                cmd,
  output iolt_pkg::dp_stat_t               stat,
  input  logic [iolt_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic [iolt_pkg::FUNC_W-1:0]      s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [iolt_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic [1:0]                       m_tuser
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > iolt_pkg::POS_W) ? CW : iolt_pkg::POS_W;

  logic [iolt_pkg::FUNC_W-1:0]    fn;
  logic [iolt_pkg::POS_W-1:0]     pos;
  logic [iolt_pkg::VAL_W-1:0]     vin;
  logic [CW-1:0]                  count, count_next;
  logic [AW-1:0]                  cursor;

  logic [CMPW-1:0]                pos_x, count_x;
  logic [AW-1:0]                  pos_a, top_a;
  logic                           full, pos_lt, pos_gt;
  iolt_pkg::status_t              st;
  iolt_pkg::plan_t                plan;

  logic [63:0]                    vin64, rd64;
  logic [WIDTH-1:0]               wval, rd_data, wr_data;
  logic [AW-1:0]                  rd_addr, wr_addr;
  logic [iolt_pkg::CNT_OUT_W-1:0] count_out;
  logic [iolt_pkg::VAL_W-1:0]     value_out;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      fn  <= s_tuser;
      pos <= s_tdata[iolt_pkg::POS_W-1:0];
      vin <= s_tdata[iolt_pkg::POS_W +: iolt_pkg::VAL_W];
    end
  end

  assign pos_x   = CMPW'(pos);
  assign count_x = CMPW'(count);
  assign pos_a   = pos_x[AW-1:0];
  assign top_a   = AW'(count_x - CMPW'(1));
  assign full    = (count == CW'(DEPTH));
  assign pos_lt  = (pos_x < count_x);
  assign pos_gt  = (pos_x > count_x);

  always_comb begin
    st   = iolt_pkg::ST_OK;
    plan = iolt_pkg::PL_NONE;
    case (fn)
      iolt_pkg::FN_READ: begin
        if (pos_lt) plan = iolt_pkg::PL_READ;
        else        st   = iolt_pkg::ST_RANGE;
      end
      iolt_pkg::FN_WRITE: begin
        if (pos_lt) plan = iolt_pkg::PL_WRITE;
        else        st   = iolt_pkg::ST_RANGE;
      end
      iolt_pkg::FN_INSERT: begin
        if (pos_gt) begin
          st = iolt_pkg::ST_RANGE;
        end else if (full) begin
          st = iolt_pkg::ST_FULL;
        end else if (pos_x == count_x) begin
          plan = iolt_pkg::PL_APPEND;
        end else begin
          plan = iolt_pkg::PL_SHIFT_UP;
        end
      end
      iolt_pkg::FN_REMOVE: begin
        if (!pos_lt) begin
          st = iolt_pkg::ST_RANGE;
        end else if ((pos_x + CMPW'(1)) != count_x) begin
          plan = iolt_pkg::PL_SHIFT_DOWN;
        end
      end
      iolt_pkg::FN_APPEND: begin
        if (full) st   = iolt_pkg::ST_FULL;
        else      plan = iolt_pkg::PL_APPEND;
      end
      default: ;
    endcase
  end

  always_comb begin
    count_next = count;
    if (st == iolt_pkg::ST_OK) begin
      case (fn)
        iolt_pkg::FN_INSERT,
        iolt_pkg::FN_APPEND: count_next = count + CW'(1);
        iolt_pkg::FN_REMOVE: count_next = count - CW'(1);
        iolt_pkg::FN_CLEAR:  count_next = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cur_load) begin
      cursor <= (plan == iolt_pkg::PL_SHIFT_UP) ? top_a : AW'(pos_x + CMPW'(1));
    end else if (cmd.cur_step) begin
      cursor <= (plan == iolt_pkg::PL_SHIFT_UP) ? cursor - AW'(1) : cursor + AW'(1);
    end
  end

  assign vin64 = {32'b0, vin};
  assign wval  = vin64[WIDTH-1:0];

  assign rd_addr = cmd.rd_cursor ? cursor : pos_a;
  assign wr_data = cmd.wdata_shift ? rd_data : wval;

  always_comb begin
    case (cmd.wsel)
      iolt_pkg::WA_COUNT: wr_addr = count_x[AW-1:0];
      iolt_pkg::WA_UP:    wr_addr = cursor + AW'(1);
      iolt_pkg::WA_DOWN:  wr_addr = cursor - AW'(1);
      default:            wr_addr = pos_a;
    endcase
  end

  iolt_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd64      = 64'(rd_data);
  assign value_out = (plan == iolt_pkg::PL_READ) ? rd64[iolt_pkg::VAL_W-1:0] : '0;
  assign count_out = iolt_pkg::CNT_OUT_W'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      count    <= count_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= {3'b000, count_out, value_out};
      m_tuser <= st;
    end
  end

  assign stat.plan     = plan;
  assign stat.at_pos   = (cursor == pos_a);
  assign stat.at_top   = (cursor == top_a);
  assign stat.out_free = !m_tvalid || m_tready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above capacity");

  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> m_tvalid)
    else $error("result not presented after finish");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.finish |=> $stable(count))
    else $error("fill count changed outside finish");

endmodule

/* rtl/core/indexed_ordered_list_table.sv */
// Top level of the indexed ordered list table: controller plus datapath.
// Depends on iolt_pkg, iolt_ctrl, iolt_dp (and iolt_ram through iolt_dp).
`timescale 1ns / 1ps

// Ordered list of up to DEPTH entries in a RAM with one write and one registered read
// port, plus a fill count; no clearing pass is needed after reset. One item at a time:
// an item is taken in the idle cycle, decoded in the next, and its result is loaded
// into the output register in a finish cycle. Read, write, append, clear and any
// error go from decode straight to finish; a read's RAM data is ready there.
// Insert before position p < count moves count-p entries, then writes the new value;
// insert at p = count takes the append path. Remove at p moves count-1-p entries.
// Each moved entry costs a RAM read and a write, which sets the shift loop length.
// The finish cycle repeats until the output register is free. A new item is
// accepted while an earlier result still waits on the master side.
module indexed_ordered_list_table #(
  parameter int DEPTH = iolt_pkg::DEPTH_DEF,
  parameter int WIDTH = iolt_pkg::WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [iolt_pkg::S_TDATA_W-1:0] s_tdata,  // position[4:0], value_in[36:5], zero pad
  input  logic [iolt_pkg::FUNC_W-1:0]    s_tuser,  // func[2:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [iolt_pkg::M_TDATA_W-1:0] m_tdata,  // value_out[31:0], entry_count[36:32], pad
  output logic [1:0]                     m_tuser   // status[1:0]
);

  iolt_pkg::dp_cmd_t  cmd;
  iolt_pkg::dp_stat_t stat;

  iolt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  iolt_dp #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

/* tb/sv/indexed_ordered_list_table_tb.sv */
// Self-checking testbench for indexed_ordered_list_table: directed table, then random phases.
// Predicts untyped results from its own list copy; depends on iolt_pkg and the RTL only.
`timescale 1ns / 1ps

module indexed_ordered_list_table_tb;
  import iolt_pkg::*;

  localparam int LIST_DEPTH   = DEPTH_DEF;
  localparam int RANDOM_OPS   = 850;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;

  localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIX, PH_NOISE} phase_t;

  typedef struct packed {
    logic [VAL_W-1:0]     value;
    status_t              status;
    logic [CNT_OUT_W-1:0] count;
  } list_result_t;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  val;
    bit                typed;
    list_result_t      want;
  } list_op_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [FUNC_W-1:0]    s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [1:0]           m_tuser;

  logic [VAL_W-1:0] model_list [LIST_DEPTH];
  int               model_count;
  list_result_t     pending_results[$];
  list_op_t         directed_ops[$];
  int               mismatch_count;
  int               idle_cycles;
  int               burst_left;
  int               steady_left;
  int               hold_req;
  int               hold_seen;
  int               hold_left;
  int               rx_cycle;
  int               rx_mode;

  indexed_ordered_list_table DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // list predictor: applies one operation to the local copy, returns the result
  function automatic list_result_t apply_list_op(input logic [FUNC_W-1:0] op,
                                                 input logic [POS_W-1:0] idx,
                                                 input logic [VAL_W-1:0] data);
    list_result_t r;
    int           i;
    r.value  = '0;
    r.status = ST_OK;
    case (op)
      FN_READ: begin
        if (idx < model_count) r.value = model_list[idx];
        else r.status = ST_RANGE;
      end
      FN_WRITE: begin
        if (idx < model_count) model_list[idx] = data;
        else r.status = ST_RANGE;
      end
      FN_INSERT: begin
        if (idx > model_count) begin
          r.status = ST_RANGE;
        end else if (model_count >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = model_count; i > idx; i--) model_list[i] = model_list[i-1];
          model_list[idx] = data;
          model_count++;
        end
      end
      FN_REMOVE: begin
        if (idx < model_count) begin
          for (i = idx; i + 1 < model_count; i++) model_list[i] = model_list[i+1];
          model_count--;
        end else begin
          r.status = ST_RANGE;
        end
      end
      FN_APPEND: begin
        if (model_count >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          model_list[model_count] = data;
          model_count++;
        end
      end
      FN_CLEAR: model_count = 0;
      default: ;
    endcase
    r.count = model_count[CNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic list_op_t pick_op(input phase_t ph);
    list_op_t r;
    int       roll;
    roll    = $urandom_range(0, 99);
    r.typed = 1'b0;
    r.want  = '0;
    case ($urandom_range(0, 7))
      0: r.val = '0;
      1: r.val = '1;
      default: r.val = $urandom;
    endcase
    case (ph)
      PH_FILL:  r.func = roll < 55 ? FN_APPEND : roll < 90 ? FN_INSERT :
                         roll < 95 ? FN_READ : FN_WRITE;
      PH_DRAIN: r.func = roll < 60 ? FN_REMOVE : roll < 80 ? FN_READ :
                         roll < 90 ? FN_WRITE : FN_INSERT;
      PH_MIX:   r.func = roll < 2 ? FN_CLEAR : FUNC_W'(roll % 5);
      default:  r.func = FUNC_W'($urandom_range(0, 7));
    endcase
    if (r.func == FN_INSERT) r.pos = POS_W'($urandom_range(0, model_count));
    else if (model_count == 0) r.pos = '0;
    else r.pos = POS_W'($urandom_range(0, model_count - 1));
    if (ph == PH_NOISE || $urandom_range(0, 9) == 0) r.pos = POS_W'($urandom_range(0, 31));
    return r;
  endfunction

  task automatic add_row(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos,
                         input logic [VAL_W-1:0] val, input bit typed,
                         input logic [VAL_W-1:0] value, input status_t status,
                         input int count);
    list_op_t r;
    r.func         = func;
    r.pos          = pos;
    r.val          = val;
    r.typed        = typed;
    r.want.value   = value;
    r.want.status  = status;
    r.want.count   = CNT_OUT_W'(count);
    directed_ops.push_back(r);
  endtask

  task automatic send_op(input list_op_t op);
    list_result_t predicted;
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W-POS_W-VAL_W){1'b0}}, op.val, op.pos};
    s_tuser  <= op.func;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = apply_list_op(op.func, op.pos, op.val);
    pending_results.push_back(op.typed ? op.want : predicted);
  endtask

  task automatic pace_sender();
    int gap;
    if (steady_left > 0) begin
      steady_left--;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = $urandom_range(1, 8);
      burst_left = $urandom_range(0, 15);
      s_tvalid  <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  initial begin
    list_op_t op;
    phase_t   ph;
    int       sent;
    int       phase_no;
    int       len;
    int       roll;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    mismatch_count = 0;
    model_count    = 0;
    burst_left     = 0;
    steady_left    = 0;
    hold_req       = 0;
    sent           = 0;
    phase_no       = 0;

    add_row(FN_READ,    0,  32'h0,        1, 32'h0,        ST_RANGE, 0);
    add_row(FN_REMOVE,  0,  32'h0,        1, 32'h0,        ST_RANGE, 0);
    add_row(FN_WRITE,   0,  32'h12345678, 1, 32'h0,        ST_RANGE, 0);
    add_row(FN_INSERT,  1,  32'h0,        1, 32'h0,        ST_RANGE, 0);
    add_row(FN_CLEAR,   0,  32'h0,        1, 32'h0,        ST_OK,    0);
    add_row(FN_SPARE_6, 5,  32'hFFFFFFFF, 1, 32'h0,        ST_OK,    0);
    add_row(FN_APPEND,  31, 32'hFFFFFFFF, 1, 32'h0,        ST_OK,    1);
    add_row(FN_READ,    0,  32'h0,        1, 32'hFFFFFFFF, ST_OK,    1);
    add_row(FN_INSERT,  0,  32'h0,        0, 32'h0,        ST_OK,    0);
    add_row(FN_INSERT,  2,  32'hA5A5A5A5, 0, 32'h0,        ST_OK,    0);
    add_row(FN_INSERT,  1,  32'h5A5A5A5A, 0, 32'h0,        ST_OK,    0);
    add_row(FN_WRITE,   4,  32'h0,        1, 32'h0,        ST_RANGE, 4);
    add_row(FN_WRITE,   1,  32'h0F0F0F0F, 0, 32'h0,        ST_OK,    0);
    add_row(FN_READ,    0,  32'h0,        0, 32'h0,        ST_OK,    0);
    add_row(FN_READ,    1,  32'h0,        0, 32'h0,        ST_OK,    0);
    add_row(FN_READ,    2,  32'h0,        0, 32'h0,        ST_OK,    0);
    add_row(FN_READ,    3,  32'h0,        0, 32'h0,        ST_OK,    0);
    add_row(FN_READ,    4,  32'h0,        1, 32'h0,        ST_RANGE, 4);
    add_row(FN_READ,    31, 32'h0,        1, 32'h0,        ST_RANGE, 4);
    add_row(FN_REMOVE,  3,  32'h0,        0, 32'h0,        ST_OK,    0);
    add_row(FN_REMOVE,  0,  32'h0,        0, 32'h0,        ST_OK,    0);
    add_row(FN_SPARE_7, 16, 32'hFFFFFFFF, 1, 32'h0,        ST_OK,    2);
    add_row(FN_INSERT,  16, 32'h0,        1, 32'h0,        ST_RANGE, 2);
    add_row(FN_CLEAR,   0,  32'h0,        1, 32'h0,        ST_OK,    0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_ops[i]) begin
      send_op(directed_ops[i]);
      pace_sender();
    end
    wait_all_results();

    while (sent < RANDOM_OPS) begin
      phase_no++;
      roll = $urandom_range(0, 99);
      ph   = phase_no == 1 ? PH_FILL : roll < 35 ? PH_FILL : roll < 60 ? PH_DRAIN :
             roll < 90 ? PH_MIX : PH_NOISE;
      len  = $urandom_range(10, 60);
      if (phase_no == 3 || $urandom_range(0, 7) == 0) begin
        // long output stall while items keep coming back to back
        hold_req   <= hold_req + 1;
        steady_left = 40;
      end
      if (phase_no == 6 || $urandom_range(0, 4) == 0) wait_all_results();
      for (int k = 0; k < len && sent < RANDOM_OPS; k++) begin
        op = pick_op(ph);
        send_op(op);
        if (op.func <= FN_CLEAR) sent++;
        pace_sender();
      end
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatch_count += pending_results.size();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // receiver: changing stall modes, plus long hold-offs on request
  initial begin
    m_tready  = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    rx_cycle  = 0;
    rx_mode   = 0;
  end

  always @(posedge clk) begin
    rx_cycle++;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = $urandom_range(150, 300);
    end
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= $urandom_range(0, 1);
        2: m_tready <= $urandom_range(0, 3) == 0;
        default: m_tready <= (rx_cycle % 5) < 3;
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected item value=%h status=%0d count=%0d", $time,
                   m_tdata[31:0], m_tuser, m_tdata[36:32]);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[31:0] !== want.value || m_tuser !== want.status ||
            m_tdata[36:32] !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch exp value=%h status=%0d count=%0d, got value=%h status=%0d count=%0d",
                     $time, want.value, want.status, want.count,
                     m_tdata[31:0], m_tuser, m_tdata[36:32]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
